>>> design/lkv_pkg.sv
// Shared constants and types of the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_BITS   = IDX_BITS;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);

    // Field widths on the ports.
    localparam int OPCODE_W    = 1;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int OCCUPANCY_W = 5;
    localparam int CAPACITY_W  = 5;

    localparam int S_TDATA_W = KEY_W + VALUE_W;
    localparam int M_RAW_W   = 1 + VALUE_W + 1 + OCCUPANCY_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register word indexes.
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(16);

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [AGE_BITS-1:0]   age_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;

endpackage

>>> design/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
// The cache takes one get or put item per cycle on the s_ channel: s_tuser
// carries the opcode and s_tdata the key and the value. Every item yields
// exactly one result item on the m_ channel: the hit flag, the value read by a
// get hit, the eviction flag and the occupancy after the operation.
// An accepted item is held in an input register. While it is there its key
// is compared against all sixteen entries at once and the new recency ranks
// and the result are worked out. Once the output register is free or being
// emptied, the next edge updates the cache and loads the output register,
// which then offers the result. One item per cycle is sustained for as long as
// the receiver keeps m_tready high.
// When the receiver stalls, the finished result waits in the output register
// and the next item waits in the input register; s_tready then falls until the
// output register drains, so no item is lost or reordered.
// The capacity register (address 0 of the APB port, reset value 16) limits
// how many entries are held before the least recently used one is evicted; a
// capacity of zero behaves as one and values above sixteen behave as sixteen.
// Reset empties the cache at once: all valid bits, ranks and the fill count
// are cleared, and keys and values are simply overwritten as entries fill.
// Capacity should only be written while no item is in flight.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] lookup_key, [63:32] put_value
    input  logic [OPCODE_W-1:0]  s_tuser,   // [0] opcode (0 get, 1 put)

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] hit, [32:1] read_value,
                                            // [33] evicted, [38:34] occupancy, rest zero

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // Configuration register.
    logic [CAPACITY_W-1:0] capacity_reg;
    count_t                cap_eff;

    // Input register.
    logic   in_valid_reg;
    op_t    in_op_reg;
    key_t   in_key_reg;
    value_t in_value_reg;

    // Cache contents.
    logic   valid_reg [ENTRIES];
    key_t   key_reg   [ENTRIES];
    value_t value_reg [ENTRIES];
    age_t   age_reg   [ENTRIES];
    count_t count_reg;

    logic   valid_next [ENTRIES];
    key_t   key_next   [ENTRIES];
    value_t value_next [ENTRIES];
    age_t   age_next   [ENTRIES];
    count_t count_next;

    // Output register.
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    logic   process;
    logic   hit;
    logic   full;
    logic   evict;
    idx_t   match_idx;
    idx_t   victim_idx;
    idx_t   free_idx;
    idx_t   slot;
    age_t   oldest_age;
    value_t read_value;

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An item is worked on once the output register is free or being emptied.
    assign process  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = PDATA_W'(capacity_reg);
        end
    end

    // Capacity clamped to the range one to ENTRIES.
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = COUNT_BITS'(1);
        end else if (32'(capacity_reg) > 32'(ENTRIES)) begin
            cap_eff = COUNT_BITS'(ENTRIES);
        end else begin
            cap_eff = COUNT_BITS'(capacity_reg);
        end
    end

    // Parallel match, victim and free-slot search. Ranks are unique among
    // valid entries, so the least recent entry is the one ranked count - 1.
    always_comb begin
        hit        = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        oldest_age = AGE_BITS'(count_reg - COUNT_BITS'(1));
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == in_key_reg) begin
                hit       = 1'b1;
                match_idx = IDX_BITS'(i);
            end
            if (valid_reg[i] && age_reg[i] == oldest_age) begin
                victim_idx = IDX_BITS'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_BITS'(i);
            end
        end
        full  = (count_reg >= cap_eff);
        evict = !hit && (in_op_reg == OP_PUT) && full;
        slot  = full ? victim_idx : free_idx;
    end

    assign read_value = (hit && in_op_reg == OP_GET) ? value_reg[match_idx] : '0;

    // Next contents of the cache.
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        age_next   = age_reg;
        count_next = count_reg;
        if (process) begin
            if (hit) begin
                if (in_op_reg == OP_PUT) begin
                    value_next[match_idx] = in_value_reg;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && age_reg[i] < age_reg[match_idx]) begin
                        age_next[i] = age_reg[i] + AGE_BITS'(1);
                    end
                end
                age_next[match_idx] = '0;
            end else if (in_op_reg == OP_PUT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && IDX_BITS'(i) != slot) begin
                        age_next[i] = age_reg[i] + AGE_BITS'(1);
                    end
                end
                valid_next[slot] = 1'b1;
                key_next[slot]   = in_key_reg;
                value_next[slot] = in_value_reg;
                age_next[slot]   = '0;
                if (!full) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        m_data_next = '0;
        m_data_next[0]                                = hit;
        m_data_next[VALUE_W:1]                        = VALUE_W'(read_value);
        m_data_next[VALUE_W+1]                        = evict;
        m_data_next[VALUE_W+1+OCCUPANCY_W:VALUE_W+2]  = OCCUPANCY_W'(count_next);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
                capacity_reg <= pwdata[CAPACITY_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (process) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= op_t'(s_tuser);
            in_key_reg   <= KEY_BITS'(s_tdata[KEY_W-1:0]);
            in_value_reg <= VALUE_BITS'(s_tdata[KEY_W+VALUE_W-1:KEY_W]);
        end
        if (process) begin
            m_data_reg <= m_data_next;
        end
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

>>> tb/lru_key_value_cache_tb.sv
// Self-checking testbench of the LRU key-value cache, with a clocked driver and monitor.
module lru_key_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lkv_pkg::*;

    // Cycle budget for the whole run. The slowest correct run is roughly
    // 1250 items, each waiting out the longest sender gap and the longest
    // receiver stall, plus two long hold-offs.
    localparam int RUN_LIMIT   = 1000000;
    localparam int PHASE_ITEMS = 120;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 10;

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));

    // One cache operation as it travels on the input channel.
    typedef struct packed {
        op_t    op;
        key_t   key;
        value_t value;
    } cache_op_t;

    // One result item, with its fields in the order of the m_tdata packing.
    typedef struct packed {
        logic                   hit;
        value_t                 read_value;
        logic                   evicted;
        logic [OCCUPANCY_W-1:0] occupancy;
    } cache_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [31:0] lookup_key, [63:32] put_value
    logic [OPCODE_W-1:0]  s_tuser  = '0;    // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [0] hit, [32:1] read_value, [33] evicted,
                                            // [38:34] occupancy
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    lru_key_value_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Shadow copy of the cache contents. Age is the recency rank among the
    // valid entries: 0 is the most recent one.
    logic   shadow_valid [ENTRIES];
    key_t   shadow_key   [ENTRIES];
    value_t shadow_value [ENTRIES];
    int     shadow_age   [ENTRIES];
    int     shadow_count;
    int     shadow_capacity;

    cache_op_t     pending_ops[$];       // items still to be offered on the input
    cache_result_t expected_results[$];  // predicted results, oldest first
    key_t          key_pool[$];          // keys reused in a phase so that hits occur

    int ops_queued    = 0;
    int results_seen  = 0;
    int hit_total     = 0;
    int evict_total   = 0;
    int error_count   = 0;
    int setting_count = 0;
    int cycle_count   = 0;
    bit steady_phase  = 1'b0;           // no idling on either side while set

    // Gap length in cycles. Most gaps are zero or short, and a few are long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one operation to the shadow cache and returns the result the
    // block should produce for it.
    function automatic cache_result_t predict_access(cache_op_t item);
        cache_result_t res;
        int limit;
        int match;
        int slot;
        int old_rank;
        res = '0;
        limit = shadow_capacity;
        // A capacity of zero acts as one, and one above the entry count acts
        // as the full cache.
        if (limit < 1)
            limit = 1;
        if (limit > ENTRIES)
            limit = ENTRIES;
        match = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (match < 0 && shadow_valid[i] && shadow_key[i] == item.key)
                match = i;
        if (match >= 0) begin
            res.hit = 1'b1;
            if (item.op == OP_GET)
                res.read_value = shadow_value[match];
            else
                shadow_value[match] = item.value;
            old_rank = shadow_age[match];
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && shadow_age[i] < old_rank)
                    shadow_age[i]++;
            shadow_age[match] = 0;
        end else if (item.op == OP_PUT) begin
            slot = -1;
            // A full cache, or one whose capacity has been lowered below its
            // occupancy, gives up only its single least recent entry.
            if (shadow_count >= limit) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i] && (slot < 0 || shadow_age[i] > shadow_age[slot]))
                        slot = i;
                if (slot >= 0) begin
                    shadow_valid[slot] = 1'b0;
                    shadow_count--;
                    res.evicted = 1'b1;
                end
            end
            if (slot < 0)
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!shadow_valid[i])
                        slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i])
                        shadow_age[i]++;
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = item.key;
                shadow_value[slot] = item.value;
                shadow_age[slot]   = 0;
                shadow_count++;
            end
        end
        // A get miss leaves everything as it was and reports hit, evicted and read value as zero.
        res.occupancy = OCCUPANCY_W'(shadow_count);
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Input driver. The expected result is worked out at the edge that
    // accepts an item, and the next item goes out after a random gap.
    always @(posedge aclk) begin
        cache_op_t next_op;
        int        send_wait;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_access(cache_op_t'{
                    op_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[S_TDATA_W-1:KEY_W]}));
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    next_op = pending_ops.pop_front();
                    s_tdata  <= {next_op.value, next_op.key};
                    s_tuser  <= next_op.op;
                    s_tvalid <= 1'b1;
                    send_wait = steady_phase ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver. Each accepted item is checked against the
    // oldest prediction. Twice in the run the receiver holds off for a long
    // stretch while the sender keeps offering, so the block fills and stalls.
    always @(posedge aclk) begin
        cache_result_t want;
        cache_result_t got;
        int            recv_wait;
        int            long_hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
            long_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[38:34]};
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result with none expected, actual %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("evicted", 32'(want.evicted), 32'(got.evicted));
                    check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                    hit_total   += want.hit;
                    evict_total += want.evicted;
                end
                if (results_seen == 300 || results_seen == 900)
                    long_hold = LONG_HOLD;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                recv_wait = steady_phase ? 0 : pick_gap();
                m_tready <= (recv_wait == 0);
                if (recv_wait > 0)
                    recv_wait--;
            end
        end
    end

    // Watchdog: a run that hangs is stopped and counted as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_op(input op_t op, input key_t key, input value_t value);
        pending_ops.push_back(cache_op_t'{op, key, value});
        ops_queued++;
    endtask

    // Waits until every queued item has produced its result, then lets the
    // pipeline settle before the next register write.
    task automatic wait_idle();
        while (results_seen < ops_queued)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write of the capacity register, followed by a read back of it.
    task automatic write_capacity(input logic [CAPACITY_W-1:0] cap);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= PDATA_W'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        shadow_capacity = cap;
        setting_count++;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("capacity read back", PDATA_W'(cap), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A phase of random gets and puts. Most keys come from a small pool, sized
    // a little above the capacity, so that hits, updates and evictions are all
    // frequent. A few keys of the previous pool are kept so that a lowered
    // capacity still sees hits on older entries.
    task automatic random_phase(input logic [CAPACITY_W-1:0] cap, input int items);
        int   pool_size;
        key_t key;
        op_t  op;
        write_capacity(cap);
        pool_size = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
        pool_size += $urandom_range(1, 6);
        while (key_pool.size() > 4)
            void'(key_pool.pop_front());
        if ($urandom_range(0, 2) == 0)
            key_pool.push_back('0);
        if ($urandom_range(0, 2) == 0)
            key_pool.push_back('1);
        while (key_pool.size() < pool_size)
            key_pool.push_back($urandom());
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                key = $urandom();
            op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            queue_op(op, key, $urandom());
        end
        wait_idle();
    endtask

    initial begin
        logic [CAPACITY_W-1:0] settings [10];
        settings = '{5'd16, 5'd3, 5'd31, 5'd8, 5'd2, 5'd17, 5'd16, 5'd5, 5'd1, 5'd12};
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_age[i]   = 0;
        end
        shadow_count    = 0;
        shadow_capacity = CAPACITY_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset capacity: a get on the empty cache, the
        // extreme keys and values, a put that updates a present key, and
        // get misses.
        queue_op(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        queue_op(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        queue_op(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
        wait_idle();

        // Capacity one, lowered below the two entries held: each put miss
        // evicts only the least recent entry and occupancy stays where it is.
        write_capacity(5'd1);
        queue_op(OP_PUT, 32'h0000_0011, 32'hA5A5_A5A5);
        queue_op(OP_PUT, 32'h0000_0022, 32'h5A5A_5A5A);
        queue_op(OP_GET, 32'h0000_0011, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0022, 32'h0000_0000);
        wait_idle();

        // Capacity zero behaves as capacity one.
        write_capacity(5'd0);
        queue_op(OP_PUT, 32'h0000_0033, 32'h8000_0001);
        queue_op(OP_GET, 32'h0000_0033, 32'h0000_0000);
        queue_op(OP_GET, 32'h0000_0022, 32'h0000_0000);
        wait_idle();

        // Random phases through a range of capacities. Every fourth phase
        // runs with no idling on either side.
        for (int p = 0; p < 10; p++) begin
            steady_phase = (p % 4 == 1);
            random_phase(settings[p], PHASE_ITEMS);
        end
        steady_phase = 1'b0;

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t ns: %0d results never arrived", $time, expected_results.size());
        end

        $display("Ran %0d cache operations over %0d capacity settings,",
                 ops_queued, setting_count);
        $display("with %0d hits and %0d evictions among the results.",
                 hit_total, evict_total);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
